// ===== hdl/mkas_pkg.sv =====
package mkas_pkg;

    localparam logic [1:0] PH_IDLE         = 2'd0;
    localparam logic [1:0] PH_PEND_PRESS   = 2'd1;
    localparam logic [1:0] PH_DOWN         = 2'd2;
    localparam logic [1:0] PH_PEND_RELEASE = 2'd3;

    localparam logic [2:0] CMD_NONE          = 3'd0;
    localparam logic [2:0] CMD_PRESS         = 3'd1;
    localparam logic [2:0] CMD_RELEASE       = 3'd2;
    localparam logic [2:0] CMD_ALL_OFF       = 3'd3;
    localparam logic [2:0] CMD_ALL_OFF_EMERG = 3'd4;

    localparam logic [2:0] EV_NOTE_ON   = 3'd0;
    localparam logic [2:0] EV_NOTE_OFF  = 3'd1;
    localparam logic [2:0] EV_CTRL      = 3'd2;
    localparam logic [2:0] EV_RESET     = 3'd3;
    localparam logic [2:0] EV_STOP      = 3'd4;
    localparam logic [2:0] EV_CLOCK     = 3'd5;
    localparam logic [2:0] EV_OTHER     = 3'd6;
    localparam logic [2:0] EV_TRANSPORT = 3'd7;

    localparam logic [6:0] CC_VOLUME     = 7'd7;
    localparam logic [6:0] CC_EXPRESSION = 7'd11;
    localparam logic [6:0] CC_SUSTAIN    = 7'd64;
    localparam logic [6:0] CC_SOUND_OFF  = 7'd120;
    localparam logic [6:0] CC_RESET_CTRL = 7'd121;
    localparam logic [6:0] CC_NOTES_OFF  = 7'd123;
    localparam logic [6:0] PEDAL_ON_MIN  = 7'd64;

    localparam logic [2:0] REG_CHANNELS = 3'd0;
    localparam logic [2:0] REG_LOWEST   = 3'd1;
    localparam logic [2:0] REG_PRECHG   = 3'd2;
    localparam logic [2:0] REG_PRESS    = 3'd3;
    localparam logic [2:0] REG_RELEASE  = 3'd4;

    localparam int MAX_RESULTS = 32;

    typedef struct packed {
        logic [15:0] accepted_channels;
        logic [6:0]  lowest_note;
        logic [31:0] press_delay_us;
        logic [31:0] release_delay_us;
    } mkas_cfg_t;

endpackage

// ===== hdl/mkas_cfg.sv =====
module mkas_cfg
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output mkas_pkg::mkas_cfg_t cfg
);

    logic [15:0] chan_reg;
    logic [6:0]  low_reg;
    logic [15:0] pre_reg;
    logic [15:0] prs_reg;
    logic [15:0] rel_reg;
    logic [2:0]  idx;
    logic [16:0] press_ms;

    assign idx    = paddr[4:2];
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_reg <= 16'hFFFF;
            low_reg  <= 7'd53;
            pre_reg  <= '0;
            prs_reg  <= '0;
            rel_reg  <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            case (idx)
                mkas_pkg::REG_CHANNELS: chan_reg <= pwdata[15:0];
                mkas_pkg::REG_LOWEST:   low_reg  <= pwdata[6:0];
                mkas_pkg::REG_PRECHG:   pre_reg  <= pwdata[15:0];
                mkas_pkg::REG_PRESS:    prs_reg  <= pwdata[15:0];
                mkas_pkg::REG_RELEASE:  rel_reg  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            mkas_pkg::REG_CHANNELS: prdata = {16'd0, chan_reg};
            mkas_pkg::REG_LOWEST:   prdata = {25'd0, low_reg};
            mkas_pkg::REG_PRECHG:   prdata = {16'd0, pre_reg};
            mkas_pkg::REG_PRESS:    prdata = {16'd0, prs_reg};
            mkas_pkg::REG_RELEASE:  prdata = {16'd0, rel_reg};
            default:                prdata = '0;
        endcase
    end

    // ms to us, wrapping as 32-bit like the counter
    assign press_ms = {1'b0, pre_reg} + {1'b0, prs_reg};
    assign cfg.accepted_channels = chan_reg;
    assign cfg.lowest_note       = low_reg;
    assign cfg.press_delay_us    = 32'(press_ms) * 32'd1000;
    assign cfg.release_delay_us  = 32'(rel_reg) * 32'd1000;

endmodule

// ===== hdl/midi_key_actuation_scheduler_top.sv =====
// Key actuation scheduler. Each transfer on start/busy is either a MIDI event
// (op 0) or a time tick (op 1). The block answers with one or more results,
// each shown for exactly one cycle under result_valid, the final one with
// last set; the receiver cannot stall them. Ticks and sustain pedal releases
// walk the keys one per cycle, ticks through a single shared deadline
// subtractor; release-all events clear every key together in the decode state.
// Emergency and all-off releases give a single result. busy stays high until
// the last result.
module midi_key_actuation_scheduler_top
#(
    parameter int NUM_KEYS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic        op,
    input  logic [2:0]  event_kind,
    input  logic [3:0]  channel,
    input  logic [6:0]  first_data,
    input  logic [6:0]  second_data,
    input  logic [31:0] now_us,
    output logic        result_valid,
    output logic        accepted,
    output logic [2:0]  command,
    output logic [4:0]  key_index,
    output logic        last
);

    localparam int KW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int CW = $clog2(NUM_KEYS + 1);

    typedef enum logic [2:0] {S_IDLE, S_NOTE, S_WALK, S_TAIL, S_DONE} state_t;

    mkas_pkg::mkas_cfg_t cfg;

    mkas_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    logic [15:0] hold_reg   [NUM_KEYS];
    logic        held_reg   [NUM_KEYS];
    logic        sus_reg    [NUM_KEYS];
    logic [1:0]  phase_reg  [NUM_KEYS];
    logic [31:0] due_mem    [NUM_KEYS];
    logic        pedal_reg;

    state_t      state_reg;
    logic        tick_reg;
    logic [2:0]  kind_reg;
    logic [15:0] bit_reg;
    logic [6:0]  d1_reg;
    logic [6:0]  d2_reg;
    logic [31:0] now_reg;
    logic [KW-1:0] key_reg;
    logic [CW-1:0] cnt_reg;
    logic [5:0]  nres_reg;
    logic        pend_reg;
    logic [2:0]  pcmd_reg;
    logic [4:0]  pkey_reg;
    logic        acc_reg;
    logic        rv_reg;
    logic        racc_reg;
    logic [2:0]  rcmd_reg;
    logic [4:0]  rkey_reg;
    logic        rlast_reg;

    // shared unit: wrap-safe deadline compare for the key under the cursor
    logic [31:0] diff;
    logic        due;
    assign diff = now_reg - due_mem[key_reg];
    assign due  = !diff[31];

    // note decode
    logic [7:0]  koff;
    logic        in_range;
    logic [KW-1:0] nkey;
    assign koff     = {1'b0, d1_reg} - {1'b0, cfg.lowest_note};
    assign in_range = (d1_reg >= cfg.lowest_note) && (koff < 8'(NUM_KEYS));
    assign nkey     = KW'(koff);

    assign busy         = state_reg != S_IDLE;
    assign result_valid = rv_reg;
    assign accepted     = racc_reg;
    assign command      = rcmd_reg;
    assign key_index    = rkey_reg;
    assign last         = rlast_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        logic        was;
        logic [15:0] nh;
        logic [1:0]  ph;
        logic        fire;
        logic [2:0]  fcmd;
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pedal_reg <= 1'b0;
            rv_reg    <= 1'b0;
            pend_reg  <= 1'b0;
            for (int i = 0; i < NUM_KEYS; i++)
            begin
                hold_reg[i]  <= '0;
                held_reg[i]  <= 1'b0;
                sus_reg[i]   <= 1'b0;
                phase_reg[i] <= mkas_pkg::PH_IDLE;
            end
        end
        else
        begin
            rv_reg    <= 1'b0;
            rlast_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        tick_reg <= op;
                        kind_reg <= event_kind;
                        bit_reg  <= 16'(1) << channel;
                        d1_reg   <= first_data;
                        d2_reg   <= second_data;
                        now_reg  <= now_us;
                        key_reg  <= '0;
                        cnt_reg  <= '0;
                        nres_reg <= '0;
                        pend_reg <= 1'b0;
                        acc_reg  <= 1'b1;
                        state_reg <= S_NOTE;
                    end
                end
                S_NOTE:
                begin
                    // decode and do single-key or release-all work
                    state_reg <= S_TAIL;
                    if (tick_reg)
                        state_reg <= S_WALK;
                    else if (kind_reg == mkas_pkg::EV_RESET ||
                             kind_reg == mkas_pkg::EV_STOP ||
                             kind_reg == mkas_pkg::EV_TRANSPORT ||
                             (kind_reg == mkas_pkg::EV_CTRL &&
                              (bit_reg & cfg.accepted_channels) != 16'd0 &&
                              (d1_reg == mkas_pkg::CC_SOUND_OFF ||
                               d1_reg == mkas_pkg::CC_NOTES_OFF)))
                    begin
                        for (int i = 0; i < NUM_KEYS; i++)
                        begin
                            hold_reg[i]  <= '0;
                            held_reg[i]  <= 1'b0;
                            sus_reg[i]   <= 1'b0;
                            phase_reg[i] <= mkas_pkg::PH_IDLE;
                        end
                        pedal_reg <= 1'b0;
                        pend_reg  <= 1'b1;
                        pkey_reg  <= '0;
                        pcmd_reg  <= (kind_reg == mkas_pkg::EV_RESET ||
                                      (kind_reg == mkas_pkg::EV_CTRL &&
                                       d1_reg == mkas_pkg::CC_SOUND_OFF)) ?
                                     mkas_pkg::CMD_ALL_OFF_EMERG : mkas_pkg::CMD_ALL_OFF;
                    end
                    else if (kind_reg == mkas_pkg::EV_CLOCK)
                        acc_reg <= 1'b1;
                    else if (kind_reg == mkas_pkg::EV_OTHER ||
                             (bit_reg & cfg.accepted_channels) == 16'd0)
                        acc_reg <= 1'b0;
                    else if (kind_reg == mkas_pkg::EV_NOTE_ON ||
                             kind_reg == mkas_pkg::EV_NOTE_OFF)
                    begin
                        if (!in_range)
                            acc_reg <= 1'b0;
                        else if (kind_reg == mkas_pkg::EV_NOTE_ON && d2_reg != 7'd0)
                        begin
                            was = hold_reg[nkey] != 16'd0 || sus_reg[nkey];
                            hold_reg[nkey] <= hold_reg[nkey] | bit_reg;
                            held_reg[nkey] <= 1'b1;
                            sus_reg[nkey]  <= 1'b0;
                            ph = phase_reg[nkey];
                            if (!was)
                            begin
                                if (ph == mkas_pkg::PH_PEND_RELEASE ||
                                    ph == mkas_pkg::PH_DOWN)
                                    phase_reg[nkey] <= mkas_pkg::PH_DOWN;
                                else if (cfg.press_delay_us == 32'd0)
                                begin
                                    phase_reg[nkey] <= mkas_pkg::PH_DOWN;
                                    pend_reg <= 1'b1;
                                    pcmd_reg <= mkas_pkg::CMD_PRESS;
                                    pkey_reg <= 5'(nkey);
                                end
                                else
                                begin
                                    phase_reg[nkey] <= mkas_pkg::PH_PEND_PRESS;
                                    due_mem[nkey] <= now_reg + cfg.press_delay_us;
                                end
                            end
                        end
                        else
                        begin
                            nh = hold_reg[nkey] & ~bit_reg;
                            hold_reg[nkey] <= nh;
                            if (nh == 16'd0)
                            begin
                                held_reg[nkey] <= 1'b0;
                                if (pedal_reg)
                                    sus_reg[nkey] <= 1'b1;
                                else if (phase_reg[nkey] == mkas_pkg::PH_PEND_PRESS)
                                    phase_reg[nkey] <= mkas_pkg::PH_IDLE;
                                else if (cfg.release_delay_us == 32'd0)
                                begin
                                    phase_reg[nkey] <= mkas_pkg::PH_IDLE;
                                    pend_reg <= 1'b1;
                                    pcmd_reg <= mkas_pkg::CMD_RELEASE;
                                    pkey_reg <= 5'(nkey);
                                end
                                else
                                begin
                                    phase_reg[nkey] <= mkas_pkg::PH_PEND_RELEASE;
                                    due_mem[nkey] <= now_reg + cfg.release_delay_us;
                                end
                            end
                        end
                    end
                    else
                    begin
                        case (d1_reg)
                            mkas_pkg::CC_VOLUME, mkas_pkg::CC_EXPRESSION: ;
                            mkas_pkg::CC_RESET_CTRL: pedal_reg <= 1'b0;
                            mkas_pkg::CC_SUSTAIN:
                            begin
                                pedal_reg <= d2_reg >= mkas_pkg::PEDAL_ON_MIN;
                                if (pedal_reg && d2_reg < mkas_pkg::PEDAL_ON_MIN)
                                    state_reg <= S_WALK;
                            end
                            default: acc_reg <= 1'b0;
                        endcase
                    end
                end
                S_WALK:
                begin
                    // one key per cycle; a pending result goes out first
                    fire = 1'b0;
                    fcmd = mkas_pkg::CMD_NONE;
                    ph   = phase_reg[key_reg];
                    if (tick_reg)
                    begin
                        if (nres_reg < 6'(mkas_pkg::MAX_RESULTS) && due)
                        begin
                            if (ph == mkas_pkg::PH_PEND_PRESS)
                            begin
                                fire = 1'b1;
                                fcmd = mkas_pkg::CMD_PRESS;
                                phase_reg[key_reg] <= mkas_pkg::PH_DOWN;
                            end
                            else if (ph == mkas_pkg::PH_PEND_RELEASE)
                            begin
                                fire = 1'b1;
                                fcmd = mkas_pkg::CMD_RELEASE;
                                phase_reg[key_reg] <= mkas_pkg::PH_IDLE;
                            end
                        end
                    end
                    else if (sus_reg[key_reg] && hold_reg[key_reg] == 16'd0)
                    begin
                        sus_reg[key_reg]  <= 1'b0;
                        held_reg[key_reg] <= 1'b0;
                        if (ph == mkas_pkg::PH_PEND_PRESS)
                            phase_reg[key_reg] <= mkas_pkg::PH_IDLE;
                        else if (cfg.release_delay_us == 32'd0)
                        begin
                            phase_reg[key_reg] <= mkas_pkg::PH_IDLE;
                            fire = nres_reg < 6'(mkas_pkg::MAX_RESULTS);
                            fcmd = mkas_pkg::CMD_RELEASE;
                        end
                        else
                        begin
                            phase_reg[key_reg] <= mkas_pkg::PH_PEND_RELEASE;
                            due_mem[key_reg] <= now_reg + cfg.release_delay_us;
                        end
                    end
                    if (fire)
                    begin
                        if (pend_reg)
                        begin
                            rv_reg   <= 1'b1;
                            racc_reg <= acc_reg;
                            rcmd_reg <= pcmd_reg;
                            rkey_reg <= pkey_reg;
                        end
                        pend_reg <= 1'b1;
                        pcmd_reg <= fcmd;
                        pkey_reg <= 5'(key_reg);
                        nres_reg <= nres_reg + 6'd1;
                    end
                    key_reg <= KW'(cnt_reg + CW'(1));
                    cnt_reg <= cnt_reg + CW'(1);
                    if (cnt_reg == CW'(NUM_KEYS - 1))
                        state_reg <= S_TAIL;
                end
                S_TAIL:
                begin
                    rv_reg    <= 1'b1;
                    rlast_reg <= 1'b1;
                    racc_reg  <= acc_reg;
                    rcmd_reg  <= pend_reg ? pcmd_reg : mkas_pkg::CMD_NONE;
                    rkey_reg  <= pend_reg ? pkey_reg : 5'd0;
                    pend_reg  <= 1'b0;
                    state_reg <= S_DONE;
                end
                S_DONE:
                    state_reg <= S_IDLE;
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
